// ===== hdl/archive_directory_parser_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the archive directory parser
// Clocked, reset-qualified concurrent assertion wrappers.
// ---------------------------------------------------------------------------
`ifndef ARCHIVE_DIRECTORY_PARSER_CORE_ASSERT_SVH
`define ARCHIVE_DIRECTORY_PARSER_CORE_ASSERT_SVH

// explicit clock and reset
`define ADP_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// default clock and reset names
`define ADP_ASSERT(label, prop, msg) \
   `ADP_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

// ===== hdl/adp_pkg.sv =====
// ---------------------------------------------------------------------------
// adp_pkg
// Types, codes and constant tables shared by the archive directory parser.
// ---------------------------------------------------------------------------
package adp_pkg;

   localparam int POSITION_WIDTH = 32;
   localparam int SIG_LEN        = 28;
   localparam int SIG_DEPTH      = 32;
   localparam int CSR_IDX_WIDTH  = 4;
   localparam int CSR_DATA_WIDTH = 33;
   localparam int SIZE_WIDTH     = 33;
   localparam int LIMIT_WIDTH    = 20;
   localparam int WORD_WIDTH     = 32;
   localparam int COUNT_WIDTH    = 5;

   localparam logic [LIMIT_WIDTH-1:0] DEFAULT_ENTRY_LIMIT = 20'd100000;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ARCHIVE_SIZE = 4'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ENTRY_LIMIT  = 4'd1;

   // 28-character archive signature, zero padded to a power of two
   localparam logic [7:0] SIG_TEXT [SIG_DEPTH] = '{
      8'h45, 8'h4C, 8'h45, 8'h43, 8'h54, 8'h52, 8'h4F, 8'h4E,
      8'h49, 8'h43, 8'h5F, 8'h41, 8'h52, 8'h54, 8'h53, 8'h5F,
      8'h41, 8'h52, 8'h43, 8'h48, 8'h49, 8'h56, 8'h45, 8'h5F,
      8'h46, 8'h49, 8'h4C, 8'h45, 8'h00, 8'h00, 8'h00, 8'h00
   };

   localparam logic [7:0] PKWA_TEXT [4] = '{8'h50, 8'h4B, 8'h57, 8'h41};
   localparam logic [7:0] NULL_TEXT [4] = '{8'h4E, 8'h55, 8'h4C, 8'h4C};

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_SIG   = 3'd1,
      ST_TRUNCATED = 3'd2,
      ST_TOO_MANY  = 3'd3,
      ST_BAD_METHOD = 3'd4,
      ST_SIZE_MISMATCH = 3'd5,
      ST_OVERLAP   = 3'd6,
      ST_PAST_END  = 3'd7
   } status_type;

   typedef enum logic [7:0] {
      PH_SIG    = 8'b0000_0001,
      PH_REC    = 8'b0000_0010,
      PH_NAME   = 8'b0000_0100,
      PH_LABEL  = 8'b0000_1000,
      PH_WORDS  = 8'b0001_0000,
      PH_METHOD = 8'b0010_0000,
      PH_TAIL   = 8'b0100_0000,
      PH_DONE   = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic                  result_kind;
      status_type            status;
      logic [WORD_WIDTH-1:0] entry_flags;
      logic [WORD_WIDTH-1:0] unpacked_size;
      logic [WORD_WIDTH-1:0] mod_time;
      logic [WORD_WIDTH-1:0] packed_size;
      logic [WORD_WIDTH-1:0] blob_offset;
      logic                  is_stored;
      logic [WORD_WIDTH-1:0] name_position;
      logic [WORD_WIDTH-1:0] name_length;
      logic [WORD_WIDTH-1:0] label_length;
      logic [WORD_WIDTH-1:0] directory_end;
   } rsp_type;

   function automatic rsp_type final_result(status_type st, logic [WORD_WIDTH-1:0] dir_end);
      rsp_type r;
      r               = '0;
      r.result_kind   = 1'b1;
      r.status        = st;
      r.directory_end = dir_end;
      return r;
   endfunction

endpackage

// ===== hdl/adp_channels.sv =====
// ---------------------------------------------------------------------------
// adp channel interfaces
// Valid/ready channels for archive bytes, parse results and register writes.
// ---------------------------------------------------------------------------
interface adp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface adp_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [2:0]  status;
   logic [31:0] entry_flags;
   logic [31:0] unpacked_size;
   logic [31:0] mod_time;
   logic [31:0] packed_size;
   logic [31:0] blob_offset;
   logic        is_stored;
   logic [31:0] name_position;
   logic [31:0] name_length;
   logic [31:0] label_length;
   logic [31:0] directory_end;

   modport source (output valid, output result_kind, output status, output entry_flags,
                   output unpacked_size, output mod_time, output packed_size,
                   output blob_offset, output is_stored, output name_position,
                   output name_length, output label_length, output directory_end,
                   input ready);
   modport sink   (input valid, input result_kind, input status, input entry_flags,
                   input unpacked_size, input mod_time, input packed_size,
                   input blob_offset, input is_stored, input name_position,
                   input name_length, input label_length, input directory_end,
                   output ready);
endinterface

interface adp_csr_if;
   logic                              valid;
   logic                              ready;
   logic [adp_pkg::CSR_IDX_WIDTH-1:0]  reg_index;
   logic [adp_pkg::CSR_DATA_WIDTH-1:0] wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ===== hdl/archive_directory_parser_core.sv =====
// A result is registered into the two-entry result buffer when the byte that causes it is accepted.
// Throughput: one byte per cycle; the whole parse step sits between the state
// registers and a two-entry result buffer, so req stalls only when both entries are full.
// Reset (synchronous): parse state to the signature phase, archive_size to 0,
// entry_limit to 100000, result buffer emptied.
// ---------------------------------------------------------------------------
// archive_directory_parser_core
// Byte-serial parser of an archive directory: signature check, record
// decode with method, size, offset, overlap and entry-limit checks, final status.
// ---------------------------------------------------------------------------
module archive_directory_parser_core #(
   parameter int POSITION_WIDTH = adp_pkg::POSITION_WIDTH
) (
   input  logic           clock,
   input  logic           reset,
   adp_req_if.sink        req_bus,
   adp_rsp_if.source      rsp_bus,
   adp_csr_if.sink        csr_bus
);

   localparam int PW = POSITION_WIDTH;
   localparam int WW = adp_pkg::WORD_WIDTH;
   localparam int CW = adp_pkg::COUNT_WIDTH;

   // configuration
   logic [adp_pkg::SIZE_WIDTH-1:0]  archive_size_ff;
   logic [adp_pkg::LIMIT_WIDTH-1:0] entry_limit_ff;

   // parse state
   adp_pkg::phase_type phase_ff, phase_in;
   logic [PW-1:0]  byte_pos_ff, byte_pos_in;
   logic [CW-1:0]  field_cnt_ff, field_cnt_in;
   logic [WW-1:0]  flags_ff, flags_in;
   logic [WW-1:0]  unpacked_ff, unpacked_in;
   logic [WW-1:0]  time_ff, time_in;
   logic [WW-1:0]  packed_ff, packed_in;
   logic [WW-1:0]  offset_ff, offset_in;
   logic [1:0]     method_ff, method_in;   // bit 0 PKWA, bit 1 NULL
   logic [adp_pkg::LIMIT_WIDTH-1:0] entry_cnt_ff, entry_cnt_in;
   logic [WW-1:0]  min_off_ff, min_off_in;
   logic [PW-1:0]  name_start_ff, name_start_in;
   logic [WW-1:0]  name_cnt_ff, name_cnt_in;
   logic [WW-1:0]  label_cnt_ff, label_cnt_in;

   // result buffer
   adp_pkg::rsp_type head_ff, head_in, skid_ff, skid_in;
   logic head_valid_ff, head_valid_in, skid_valid_ff, skid_valid_in;

   adp_pkg::rsp_type res;
   logic             emit;
   logic             accept;
   logic             pop;
   logic [7:0]       b;
   logic [WW-1:0]    part;
   logic [WW-1:0]    offset_full;
   logic [PW-1:0]    pos_next;
   logic [WW-1:0]    dir_end;
   logic [adp_pkg::SIZE_WIDTH-1:0] blob_end;

   assign req_bus.ready = !skid_valid_ff;
   assign accept        = req_bus.valid && req_bus.ready;
   assign pop           = head_valid_ff && rsp_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign b           = req_bus.byte_value;
   assign part        = WW'(b) << {field_cnt_ff[1:0], 3'b000};
   assign offset_full = offset_ff | part;
   assign pos_next    = byte_pos_ff + PW'(1);
   assign dir_end     = WW'(pos_next);
   assign blob_end    = {1'b0, offset_full} + {1'b0, packed_ff};

   always_comb begin
      phase_in      = phase_ff;
      byte_pos_in   = byte_pos_ff;
      field_cnt_in  = field_cnt_ff;
      flags_in      = flags_ff;
      unpacked_in   = unpacked_ff;
      time_in       = time_ff;
      packed_in     = packed_ff;
      offset_in     = offset_ff;
      method_in     = method_ff;
      entry_cnt_in  = entry_cnt_ff;
      min_off_in    = min_off_ff;
      name_start_in = name_start_ff;
      name_cnt_in   = name_cnt_ff;
      label_cnt_in  = label_cnt_ff;
      emit          = 1'b0;
      res           = '0;

      if (phase_ff != adp_pkg::PH_DONE) begin
         byte_pos_in = pos_next;
      end

      unique case (phase_ff)
         adp_pkg::PH_SIG: begin
            if (field_cnt_ff < CW'(adp_pkg::SIG_LEN)) begin
               if (b != adp_pkg::SIG_TEXT[field_cnt_ff]) begin
                  emit     = 1'b1;
                  res      = adp_pkg::final_result(adp_pkg::ST_BAD_SIG, '0);
                  phase_in = adp_pkg::PH_DONE;
               end else begin
                  field_cnt_in = field_cnt_ff + CW'(1);
               end
            end else if (b != 8'h00) begin
               emit     = 1'b1;
               res      = adp_pkg::final_result(adp_pkg::ST_BAD_SIG, '0);
               phase_in = adp_pkg::PH_DONE;
            end else begin
               phase_in     = adp_pkg::PH_REC;
               field_cnt_in = '0;
            end
         end
         adp_pkg::PH_REC: begin
            if (b == 8'h00) begin
               emit     = 1'b1;
               phase_in = adp_pkg::PH_DONE;
               if (min_off_ff < dir_end) begin
                  res = adp_pkg::final_result(adp_pkg::ST_OVERLAP, '0);
               end else begin
                  res = adp_pkg::final_result(adp_pkg::ST_OK, dir_end);
               end
            end else if (entry_cnt_ff >= entry_limit_ff) begin
               emit     = 1'b1;
               res      = adp_pkg::final_result(adp_pkg::ST_TOO_MANY, '0);
               phase_in = adp_pkg::PH_DONE;
            end else begin
               name_start_in = byte_pos_ff;
               name_cnt_in   = WW'(1);
               phase_in      = adp_pkg::PH_NAME;
            end
         end
         adp_pkg::PH_NAME: begin
            if (b == 8'h00) begin
               label_cnt_in = '0;
               phase_in     = adp_pkg::PH_LABEL;
            end else begin
               name_cnt_in = name_cnt_ff + WW'(1);
            end
         end
         adp_pkg::PH_LABEL: begin
            if (b == 8'h00) begin
               field_cnt_in = '0;
               flags_in     = '0;
               unpacked_in  = '0;
               time_in      = '0;
               phase_in     = adp_pkg::PH_WORDS;
            end else begin
               label_cnt_in = label_cnt_ff + WW'(1);
            end
         end
         adp_pkg::PH_WORDS: begin
            if (field_cnt_ff < CW'(4)) begin
               flags_in = flags_ff | part;
            end else if (field_cnt_ff < CW'(8)) begin
               unpacked_in = unpacked_ff | part;
            end else begin
               time_in = time_ff | part;
            end
            if (field_cnt_ff >= CW'(11)) begin
               field_cnt_in = '0;
               method_in    = 2'b11;
               phase_in     = adp_pkg::PH_METHOD;
            end else begin
               field_cnt_in = field_cnt_ff + CW'(1);
            end
         end
         adp_pkg::PH_METHOD: begin
            if (b == 8'h00) begin
               if (field_cnt_ff != CW'(4)) begin
                  method_in = 2'b00;
               end
               field_cnt_in = '0;
               packed_in    = '0;
               offset_in    = '0;
               phase_in     = adp_pkg::PH_TAIL;
            end else begin
               if (field_cnt_ff < CW'(4)) begin
                  method_in[0] = method_ff[0] && (b == adp_pkg::PKWA_TEXT[field_cnt_ff[1:0]]);
                  method_in[1] = method_ff[1] && (b == adp_pkg::NULL_TEXT[field_cnt_ff[1:0]]);
               end else begin
                  method_in = 2'b00;
               end
               if (field_cnt_ff != '1) begin
                  field_cnt_in = field_cnt_ff + CW'(1);
               end
            end
         end
         adp_pkg::PH_TAIL: begin
            if (field_cnt_ff < CW'(4)) begin
               packed_in = packed_ff | part;
            end else begin
               offset_in = offset_full;
            end
            if (field_cnt_ff >= CW'(7)) begin
               field_cnt_in = '0;
               emit         = 1'b1;
               priority if (method_ff == 2'b00) begin
                  res      = adp_pkg::final_result(adp_pkg::ST_BAD_METHOD, '0);
                  phase_in = adp_pkg::PH_DONE;
               end else if (method_ff[1] && (packed_ff != unpacked_ff)) begin
                  res      = adp_pkg::final_result(adp_pkg::ST_SIZE_MISMATCH, '0);
                  phase_in = adp_pkg::PH_DONE;
               end else if (blob_end > archive_size_ff) begin
                  res      = adp_pkg::final_result(adp_pkg::ST_PAST_END, '0);
                  phase_in = adp_pkg::PH_DONE;
               end else begin
                  res.result_kind   = 1'b0;
                  res.status        = adp_pkg::ST_OK;
                  res.entry_flags   = flags_ff;
                  res.unpacked_size = unpacked_ff;
                  res.mod_time      = time_ff;
                  res.packed_size   = packed_ff;
                  res.blob_offset   = offset_full;
                  res.is_stored     = method_ff[1];
                  res.name_position = WW'(name_start_ff);
                  res.name_length   = name_cnt_ff;
                  res.label_length  = label_cnt_ff;
                  res.directory_end = '0;
                  if (offset_full < min_off_ff) begin
                     min_off_in = offset_full;
                  end
                  entry_cnt_in = entry_cnt_ff + adp_pkg::LIMIT_WIDTH'(1);
                  phase_in     = adp_pkg::PH_REC;
               end
            end else begin
               field_cnt_in = field_cnt_ff + CW'(1);
            end
         end
         default: begin
         end
      endcase

      // end of buffer: truncation if still parsing, then back to reset state
      if (req_bus.last_byte) begin
         if (phase_in != adp_pkg::PH_DONE) begin
            emit = 1'b1;
            res  = adp_pkg::final_result(adp_pkg::ST_TRUNCATED, '0);
         end
         phase_in      = adp_pkg::PH_SIG;
         byte_pos_in   = '0;
         field_cnt_in  = '0;
         flags_in      = '0;
         unpacked_in   = '0;
         time_in       = '0;
         packed_in     = '0;
         offset_in     = '0;
         method_in     = '0;
         entry_cnt_in  = '0;
         min_off_in    = '1;
         name_start_in = '0;
         name_cnt_in   = '0;
         label_cnt_in  = '0;
      end
   end

   always_comb begin
      head_in       = head_ff;
      skid_in       = skid_ff;
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept && emit) begin
         if (!head_valid_ff || pop) begin
            head_in       = res;
            head_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         head_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         archive_size_ff <= '0;
         entry_limit_ff  <= adp_pkg::DEFAULT_ENTRY_LIMIT;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.reg_index)
            adp_pkg::CSR_ARCHIVE_SIZE: archive_size_ff <= csr_bus.wr_data;
            adp_pkg::CSR_ENTRY_LIMIT:
               entry_limit_ff <= csr_bus.wr_data[adp_pkg::LIMIT_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= adp_pkg::PH_SIG;
         byte_pos_ff   <= '0;
         field_cnt_ff  <= '0;
         flags_ff      <= '0;
         unpacked_ff   <= '0;
         time_ff       <= '0;
         packed_ff     <= '0;
         offset_ff     <= '0;
         method_ff     <= '0;
         entry_cnt_ff  <= '0;
         min_off_ff    <= '1;
         name_start_ff <= '0;
         name_cnt_ff   <= '0;
         label_cnt_ff  <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         byte_pos_ff   <= byte_pos_in;
         field_cnt_ff  <= field_cnt_in;
         flags_ff      <= flags_in;
         unpacked_ff   <= unpacked_in;
         time_ff       <= time_in;
         packed_ff     <= packed_in;
         offset_ff     <= offset_in;
         method_ff     <= method_in;
         entry_cnt_ff  <= entry_cnt_in;
         min_off_ff    <= min_off_in;
         name_start_ff <= name_start_in;
         name_cnt_ff   <= name_cnt_in;
         label_cnt_ff  <= label_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_bus.valid         = head_valid_ff;
   assign rsp_bus.result_kind   = head_ff.result_kind;
   assign rsp_bus.status        = head_ff.status;
   assign rsp_bus.entry_flags   = head_ff.entry_flags;
   assign rsp_bus.unpacked_size = head_ff.unpacked_size;
   assign rsp_bus.mod_time      = head_ff.mod_time;
   assign rsp_bus.packed_size   = head_ff.packed_size;
   assign rsp_bus.blob_offset   = head_ff.blob_offset;
   assign rsp_bus.is_stored     = head_ff.is_stored;
   assign rsp_bus.name_position = head_ff.name_position;
   assign rsp_bus.name_length   = head_ff.name_length;
   assign rsp_bus.label_length  = head_ff.label_length;
   assign rsp_bus.directory_end = head_ff.directory_end;

endmodule

// ===== hdl/adp_port_checker.sv =====
// ---------------------------------------------------------------------------
// adp_port_checker
// Port-level checks on the parser's result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "archive_directory_parser_core_assert.svh"

module adp_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        result_kind,
   input logic [2:0]  status,
   input logic [31:0] entry_flags,
   input logic [31:0] unpacked_size,
   input logic [31:0] mod_time,
   input logic [31:0] packed_size,
   input logic [31:0] blob_offset,
   input logic        is_stored,
   input logic [31:0] name_position,
   input logic [31:0] name_length,
   input logic [31:0] label_length,
   input logic [31:0] directory_end
);

   logic [346:0] rsp_payload;

   assign rsp_payload = {result_kind, status, entry_flags, unpacked_size, mod_time,
                         packed_size, blob_offset, is_stored, name_position,
                         name_length, label_length, directory_end};

   `ADP_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "stalled transaction changed")
   `ADP_ASSERT(a_rec_ok, rsp_valid && !result_kind |-> status == 3'd0 && directory_end == 32'd0, "record with bad status or directory end")
   `ADP_ASSERT(a_final_clean, rsp_valid && result_kind |-> entry_flags == 32'd0 && packed_size == 32'd0 && blob_offset == 32'd0 && is_stored == 1'b0 && name_length == 32'd0, "final status carries record fields")
   `ADP_ASSERT(a_stored_size, rsp_valid && !result_kind && is_stored |-> packed_size == unpacked_size, "stored record size mismatch")
   `ADP_ASSERT(a_end_only_ok, rsp_valid && result_kind && status != 3'd0 |-> directory_end == 32'd0, "failed status with directory end")

endmodule

bind archive_directory_parser_core adp_port_checker u_adp_port_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .result_kind   (rsp_bus.result_kind),
   .status        (rsp_bus.status),
   .entry_flags   (rsp_bus.entry_flags),
   .unpacked_size (rsp_bus.unpacked_size),
   .mod_time      (rsp_bus.mod_time),
   .packed_size   (rsp_bus.packed_size),
   .blob_offset   (rsp_bus.blob_offset),
   .is_stored     (rsp_bus.is_stored),
   .name_position (rsp_bus.name_position),
   .name_length   (rsp_bus.name_length),
   .label_length  (rsp_bus.label_length),
   .directory_end (rsp_bus.directory_end)
);
